// ===== src/msrc_pkg.sv =====
// Package for the Modbus RTU sensor response checker.
// Holds action codes, CRC-16/MODBUS constants, frame layout and shared types.
// No dependencies.
package msrc_pkg;

  // Action codes carried with each input beat
  localparam logic [1:0] ACT_BYTE = 2'd0;  // frame byte
  localparam logic [1:0] ACT_LAST = 2'd1;  // last byte of frame
  localparam logic [1:0] ACT_FAIL = 2'd2;  // exchange failed, no frame
  localparam logic [1:0] ACT_NOP  = 2'd3;  // unused, ignored

  // CRC-16/MODBUS
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Frame layout: seven big-endian readings in bytes 3..16
  localparam int unsigned NUM_READINGS = 7;
  localparam logic [4:0]  RD_FIRST     = 5'd3;
  localparam logic [4:0]  RD_LAST      = 5'd16;
  localparam logic [4:0]  POS_MAX      = 5'd31;

  localparam logic [6:0]  LIMIT_RESET  = 7'd60;

  typedef logic [NUM_READINGS-1:0][15:0] reading_arr_t;

  // End-of-exchange status from the frame receiver
  typedef struct packed {
    logic exch_end;    // beat closes an exchange (last byte or failure)
    logic frame_good;  // right length and CRC residue zero
  } frame_status_t;

  // One byte of CRC-16/MODBUS, LSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== src/msrc_frame_rx.sv =====
// Frame receiver: running CRC, byte position and staged readings.
// Depends on msrc_pkg.
module msrc_frame_rx #(
  parameter int unsigned FRAME_LEN = 19
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  beat,
  input  logic [1:0]            action,
  input  logic [7:0]            rx_byte,
  output msrc_pkg::frame_status_t status,
  output msrc_pkg::reading_arr_t  staged
);
  import msrc_pkg::*;

  localparam logic [4:0] LEN_M1 = 5'(FRAME_LEN - 1);

  logic [15:0]  crc_r, crc_nxt, crc_upd;
  logic [4:0]   pos_r, pos_nxt;
  reading_arr_t staged_r;
  logic         in_rd_span;
  logic [4:0]   rd_off;
  logic [2:0]   rd_idx;

  assign crc_upd    = crc16_byte(crc_r, rx_byte);
  assign in_rd_span = (pos_r >= RD_FIRST) && (pos_r <= RD_LAST);
  assign rd_off     = pos_r - RD_FIRST;
  assign rd_idx     = rd_off[3:1];

  // Exchange status for the current beat
  always_comb begin
    status.exch_end   = beat && ((action == ACT_LAST) || (action == ACT_FAIL));
    status.frame_good = (action == ACT_LAST) && (pos_r == LEN_M1) && (crc_upd == 16'h0000);
  end

  // CRC and position next state
  always_comb begin
    crc_nxt = crc_r;
    pos_nxt = pos_r;
    if (beat) begin
      case (action)
        ACT_BYTE: begin
          crc_nxt = crc_upd;
          pos_nxt = (pos_r == POS_MAX) ? pos_r : pos_r + 5'd1;
        end
        ACT_LAST, ACT_FAIL: begin
          crc_nxt = CRC_INIT;
          pos_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_INIT;
      pos_r <= '0;
    end else begin
      crc_r <= crc_nxt;
      pos_r <= pos_nxt;
    end
  end

  // Staged readings: odd position is the high byte
  always_ff @(posedge clk) begin
    if (beat && ((action == ACT_BYTE) || (action == ACT_LAST)) && in_rd_span) begin
      for (int r = 0; r < NUM_READINGS; r++) begin
        if (rd_idx == 3'(r)) begin
          if (pos_r[0]) staged_r[r][15:8] <= rx_byte;
          else          staged_r[r][7:0]  <= rx_byte;
        end
      end
    end
  end

  assign staged = staged_r;

endmodule

// ===== src/modbus_sensor_response_checker.sv =====
// Top level of the Modbus RTU soil sensor response checker.
// Depends on msrc_pkg and msrc_frame_rx.
//
// Usage:
//   Input channel (in_valid / in_stall): one beat per received byte, with
//   in_action telling a frame byte, the last byte of a frame, or a failed
//   exchange. Frame bytes give no result; last byte and failure give one.
//   Output channel (out_valid / out_stall): one beat per exchange with the
//   frame check, the seven held readings, the available flag and the
//   failure count.
//   Config channel (cfg_valid / cfg_ready): writes failure_limit; always
//   ready, write only while the block is idle.
// The result shows in the cycle after the closing input beat.
// Throughput: one input beat per cycle while in_stall is low; the CRC
// byte update and the counter compare sit between the input and the
// result registers. While a result is held by out_stall, in_stall is
// raised; it drops in the cycle the result is taken.
// Reset (rst_n low, synchronous): CRC 0xFFFF, position zero, readings
// zero, flag and count cleared, failure_limit 60, no result pending.
module modbus_sensor_response_checker #(
  parameter int unsigned FRAME_LEN = 19
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_frame_ok,
  output logic [15:0] out_moisture_tenths,
  output logic [15:0] out_temperature_tenths,
  output logic [15:0] out_conductivity,
  output logic [15:0] out_ph_tenths,
  output logic [15:0] out_nitrogen,
  output logic [15:0] out_phosphorus,
  output logic [15:0] out_potassium,
  output logic        out_sensor_available,
  output logic [6:0]  out_failure_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_failure_limit
);
  import msrc_pkg::*;

  logic          in_beat;
  frame_status_t status;
  reading_arr_t  staged;

  reading_arr_t  held_r, held_nxt;
  logic [6:0]    limit_r;
  logic [6:0]    cnt_r, cnt_nxt, cnt_inc;
  logic          avail_r, avail_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          ok_r, ok_nxt;

  // Input beat; held off only while a result is stuck at the output
  assign in_stall  = out_valid_r && out_stall;
  assign in_beat   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  msrc_frame_rx #(.FRAME_LEN(FRAME_LEN)) u_rx (
    .clk     (clk),
    .rst_n   (rst_n),
    .beat    (in_beat),
    .action  (in_action),
    .rx_byte (in_rx_byte),
    .status  (status),
    .staged  (staged)
  );

  // Exchange outcome: latch readings or count a failure
  assign cnt_inc = cnt_r + 7'd1;

  always_comb begin
    held_nxt  = held_r;
    avail_nxt = avail_r;
    cnt_nxt   = cnt_r;
    if (status.exch_end) begin
      if (status.frame_good) begin
        held_nxt  = staged;
        avail_nxt = 1'b1;
      end else if (cnt_inc == limit_r) begin
        avail_nxt = 1'b0;
        cnt_nxt   = '0;
      end else begin
        cnt_nxt = cnt_inc;
      end
    end
  end

  // Result beat register
  always_comb begin
    out_valid_nxt = out_valid_r;
    ok_nxt        = ok_r;
    if (!in_stall) begin
      out_valid_nxt = status.exch_end;
      if (status.exch_end) ok_nxt = status.frame_good;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      avail_r     <= 1'b0;
      cnt_r       <= '0;
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
      ok_r        <= 1'b0;
    end else begin
      held_r      <= held_nxt;
      avail_r     <= avail_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      ok_r        <= ok_nxt;
      if (cfg_valid && cfg_ready) limit_r <= cfg_failure_limit;
    end
  end

  // Held state only changes when a new result loads, so it drives the beat
  assign out_valid              = out_valid_r;
  assign out_frame_ok           = ok_r;
  assign out_moisture_tenths    = held_r[0];
  assign out_temperature_tenths = held_r[1];
  assign out_conductivity       = held_r[2];
  assign out_ph_tenths          = held_r[3];
  assign out_nitrogen           = held_r[4];
  assign out_phosphorus         = held_r[5];
  assign out_potassium          = held_r[6];
  assign out_sensor_available   = avail_r;
  assign out_failure_count      = cnt_r;

  // A good frame always leaves the sensor available
  a_ok_avail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_ok |-> out_sensor_available)
    else $error("good frame without sensor available");

  // A failed exchange yields a failing result next cycle
  a_fail_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_action == ACT_FAIL) |=> out_valid && !out_frame_ok)
    else $error("failed exchange did not produce a failing result");

  // Frame bytes never move the failure count
  a_byte_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_action == ACT_BYTE) |=> $stable(out_failure_count))
    else $error("failure count changed on a frame byte");

  // A good frame leaves the failure count unchanged
  a_ok_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    status.exch_end && status.frame_good |=> $stable(out_failure_count))
    else $error("failure count changed on a good frame");

endmodule

// ===== bench/modbus_sensor_response_checker_tb.sv =====
// Testbench for modbus_sensor_response_checker: drives response bytes and checks each
// exchange report against a local model of the CRC check, readings and failure counter.
// Depends on msrc_pkg and the modbus_sensor_response_checker RTL.
`timescale 1ns / 100ps

module modbus_sensor_response_checker_tb;
  import msrc_pkg::*;

  localparam int FRAME_LEN     = 19;
  localparam int ITEMS_PER_PHASE = 207;
  localparam int NUM_PHASES    = 4;
  localparam int DRAIN_CYCLES  = 4;
  localparam int QUIET_LIMIT   = 3000;
  localparam int LONG_HOLD     = 60;
  localparam int SHOWN_ERRORS  = 10;

  // One exchange report as seen on the result channel
  typedef struct packed {
    logic         ok;
    reading_arr_t rd;
    logic         avail;
    logic [6:0]   cnt;
  } exch_result_t;

  // One directed stimulus row; want is used only when typed is set
  typedef struct {
    logic [1:0]   act;
    logic [7:0]   data;
    bit           typed;
    exch_result_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_action = ACT_NOP;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_frame_ok;
  logic [15:0] out_moisture_tenths;
  logic [15:0] out_temperature_tenths;
  logic [15:0] out_conductivity;
  logic [15:0] out_ph_tenths;
  logic [15:0] out_nitrogen;
  logic [15:0] out_phosphorus;
  logic [15:0] out_potassium;
  logic        out_sensor_available;
  logic [6:0]  out_failure_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_failure_limit = LIMIT_RESET;

  modbus_sensor_response_checker #(.FRAME_LEN(FRAME_LEN)) dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_action              (in_action),
    .in_rx_byte             (in_rx_byte),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_frame_ok           (out_frame_ok),
    .out_moisture_tenths    (out_moisture_tenths),
    .out_temperature_tenths (out_temperature_tenths),
    .out_conductivity       (out_conductivity),
    .out_ph_tenths          (out_ph_tenths),
    .out_nitrogen           (out_nitrogen),
    .out_phosphorus         (out_phosphorus),
    .out_potassium          (out_potassium),
    .out_sensor_available   (out_sensor_available),
    .out_failure_count      (out_failure_count),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_failure_limit      (cfg_failure_limit)
  );

  always #4 clk = ~clk;

  // Model state
  logic [15:0]  crc_q;
  logic [4:0]   pos_q;
  reading_arr_t staged_q;
  reading_arr_t held_q;
  logic [6:0]   fails_q;
  logic         avail_q;
  logic [6:0]   limit_q;

  exch_result_t pending_reports[$];
  stim_row_t    directed_rows[$];
  logic [7:0]   frame_buf[$];

  int  idle_pct = 0;
  int  stall_pct = 0;
  int  items_sent = 0;
  int  mismatches = 0;
  int  quiet_cycles = 0;
  bit  hold_req = 1'b0;

  // CRC-16/MODBUS over one byte, reflected, LSB first
  function automatic logic [15:0] fold_crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        lsb;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      lsb = c[0];
      c = c >> 1;
      if (lsb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function automatic exch_result_t mk_result(input logic ok, input reading_arr_t rd,
                                             input logic avail, input logic [6:0] cnt);
    exch_result_t r;
    r.ok    = ok;
    r.rd    = rd;
    r.avail = avail;
    r.cnt   = cnt;
    return r;
  endfunction

  // Fold one frame byte into the CRC and stage reading bytes 3..16
  task automatic take_frame_byte(input logic [7:0] b);
    int idx;
    crc_q = fold_crc_byte(crc_q, b);
    if (pos_q >= RD_FIRST && pos_q <= RD_LAST) begin
      idx = (pos_q - RD_FIRST) >> 1;
      if (pos_q[0]) staged_q[idx][15:8] = b;
      else          staged_q[idx][7:0]  = b;
    end
  endtask

  // Advance the model by one accepted beat; has is set when it closes an exchange
  task automatic track_response_byte(input logic [1:0] act, input logic [7:0] b,
                                     output bit has, output exch_result_t r);
    logic ok;
    logic len_ok;
    has = 1'b0;
    r   = '0;
    ok  = 1'b0;
    if (act == ACT_NOP) return;
    if (act == ACT_BYTE) begin
      take_frame_byte(b);
      if (pos_q < POS_MAX) pos_q = pos_q + 5'd1;
      return;
    end
    if (act == ACT_LAST) begin
      len_ok = (pos_q == 5'(FRAME_LEN - 1));
      take_frame_byte(b);
      ok = len_ok && (crc_q == 16'h0000);
    end
    if (ok) begin
      avail_q = 1'b1;
      held_q  = staged_q;
    end else begin
      // counter wraps at 128 and is compared after every increment
      fails_q = fails_q + 7'd1;
      if (fails_q == limit_q) begin
        avail_q = 1'b0;
        fails_q = 7'd0;
      end
    end
    crc_q = CRC_INIT;
    pos_q = 5'd0;
    r   = mk_result(ok, held_q, avail_q, fails_q);
    has = 1'b1;
  endtask

  // Append the CRC of frame_buf, low byte first
  task automatic seal_frame();
    logic [15:0] c;
    c = CRC_INIT;
    foreach (frame_buf[i]) c = fold_crc_byte(c, frame_buf[i]);
    frame_buf.push_back(c[7:0]);
    frame_buf.push_back(c[15:8]);
  endtask

  // Build a full response frame: address, function, count, readings, CRC
  task automatic make_frame(input logic [7:0] addr, input logic [7:0] fn,
                            input logic [7:0] cnt, input reading_arr_t vals);
    frame_buf.delete();
    frame_buf.push_back(addr);
    frame_buf.push_back(fn);
    frame_buf.push_back(cnt);
    for (int i = 0; i < NUM_READINGS; i++) begin
      frame_buf.push_back(vals[i][15:8]);
      frame_buf.push_back(vals[i][7:0]);
    end
    seal_frame();
  endtask

  task automatic add_row(input logic [1:0] act, input logic [7:0] data);
    stim_row_t row;
    row.act   = act;
    row.data  = data;
    row.typed = 1'b0;
    row.want  = '0;
    directed_rows.push_back(row);
  endtask

  task automatic add_typed(input logic [1:0] act, input logic [7:0] data,
                           input exch_result_t want);
    stim_row_t row;
    row.act   = act;
    row.data  = data;
    row.typed = 1'b1;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // Offer one input beat, with random idle cycles ahead of it
  task automatic offer_beat(input logic [1:0] act, input logic [7:0] data,
                            input bit typed, input exch_result_t want);
    bit           acc;
    bit           has;
    exch_result_t r;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_action  <= act;
    in_rx_byte <= data;
    do begin
      @(negedge clk);
      acc = !in_stall;
      @(posedge clk);
    end while (!acc);
    track_response_byte(act, data, has, r);
    if (has) pending_reports.push_back(typed ? want : r);
    if (act != ACT_NOP) items_sent++;
  endtask

  // Send frame_buf as one exchange, with the odd ignored beat mixed in
  task automatic send_frame_buf();
    for (int i = 0; i < frame_buf.size(); i++) begin
      if ($urandom_range(99) < 4) offer_beat(ACT_NOP, 8'($urandom), 1'b0, '0);
      offer_beat((i == frame_buf.size() - 1) ? ACT_LAST : ACT_BYTE, frame_buf[i], 1'b0, '0);
    end
  endtask

  // One random exchange: mostly full-length frames, then broken ones and noise
  task automatic send_random_exchange();
    int           kind;
    int           len;
    int           bit_pos;
    reading_arr_t vals;
    kind = $urandom_range(99);
    if (kind < 55) begin
      for (int i = 0; i < NUM_READINGS; i++) begin
        case ($urandom_range(7))
          0:       vals[i] = 16'h0000;
          1:       vals[i] = 16'hFFFF;
          default: vals[i] = 16'($urandom);
        endcase
      end
      make_frame(8'($urandom), 8'($urandom), 8'($urandom), vals);
      // corrupt one bit now and then
      if ($urandom_range(99) < 20) begin
        bit_pos = $urandom_range(FRAME_LEN * 8 - 1);
        frame_buf[bit_pos / 8][bit_pos % 8] = ~frame_buf[bit_pos / 8][bit_pos % 8];
      end
      send_frame_buf();
    end else if (kind < 75) begin
      // any length, past the position saturation too, CRC sealed or not
      len = $urandom_range(1, 40);
      frame_buf.delete();
      if (len >= 3 && $urandom_range(1)) begin
        repeat (len - 2) frame_buf.push_back(8'($urandom));
        seal_frame();
      end else begin
        repeat (len) frame_buf.push_back(8'($urandom));
      end
      send_frame_buf();
    end else if (kind < 85) begin
      offer_beat(ACT_FAIL, 8'($urandom), 1'b0, '0);
    end else if (kind < 95) begin
      // exchange aborted part way through a frame
      repeat ($urandom_range(1, 25)) offer_beat(ACT_BYTE, 8'($urandom), 1'b0, '0);
      offer_beat(ACT_FAIL, 8'($urandom), 1'b0, '0);
    end else begin
      repeat ($urandom_range(1, 3)) offer_beat(ACT_NOP, 8'($urandom), 1'b0, '0);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_failure_limit(input logic [6:0] value);
    bit acc;
    cfg_valid         <= 1'b1;
    cfg_failure_limit <= value;
    do begin
      @(negedge clk);
      acc = cfg_ready;
      @(posedge clk);
    end while (!acc);
    cfg_valid <= 1'b0;
    limit_q = value;
  endtask

  // Result side: random stall, plus one long hold on request
  always @(posedge clk) begin : result_stall
    int hold_left;
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Result check and watchdog, sampled mid-cycle ahead of the accepting edge
  always @(negedge clk) begin : result_check
    exch_result_t got;
    exch_result_t want;
    bit           moved;
    moved = 1'b0;
    if (rst_n) begin
      moved = (in_valid && !in_stall) || (cfg_valid && cfg_ready);
      if (out_valid && !out_stall) begin
        moved        = 1'b1;
        got.ok       = out_frame_ok;
        got.rd[0]    = out_moisture_tenths;
        got.rd[1]    = out_temperature_tenths;
        got.rd[2]    = out_conductivity;
        got.rd[3]    = out_ph_tenths;
        got.rd[4]    = out_nitrogen;
        got.rd[5]    = out_phosphorus;
        got.rd[6]    = out_potassium;
        got.avail    = out_sensor_available;
        got.cnt      = out_failure_count;
        if (pending_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOWN_ERRORS)
            $display("%0t: report beat with nothing pending: ok=%0d avail=%0d cnt=%0d",
                     $realtime, got.ok, got.avail, got.cnt);
        end else begin
          want = pending_reports.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= SHOWN_ERRORS) begin
              $display("%0t: report mismatch", $realtime);
              $display("  exp ok=%0d avail=%0d cnt=%0d rd=%h", want.ok, want.avail,
                       want.cnt, want.rd);
              $display("  got ok=%0d avail=%0d cnt=%0d rd=%h", got.ok, got.avail,
                       got.cnt, got.rd);
            end
          end
        end
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d reports pending",
               quiet_cycles, pending_reports.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    reading_arr_t dvals;
    int           start;
    bit           hold_done;
    bit           pause_done;
    logic [6:0]   limits[NUM_PHASES];
    int           idle_tab[NUM_PHASES];
    int           stall_tab[NUM_PHASES];

    limits    = '{7'd1, 7'd127, 7'd0, 7'($urandom_range(2, 9))};
    idle_tab  = '{0, 88, 0, 19};
    stall_tab = '{0, 0, 88, 19};
    hold_done  = 1'b0;
    pause_done = 1'b0;

    crc_q    = CRC_INIT;
    pos_q    = 5'd0;
    staged_q = '0;
    held_q   = '0;
    fails_q  = 7'd0;
    avail_q  = 1'b0;
    limit_q  = LIMIT_RESET;

    // Directed rows: reset state, ignored beat, short frame, good frame of extremes
    add_typed(ACT_FAIL, 8'hFF, mk_result(1'b0, '0, 1'b0, 7'd1));
    add_row(ACT_NOP, 8'hA5);
    add_typed(ACT_LAST, 8'h00, mk_result(1'b0, '0, 1'b0, 7'd2));
    // reading 6 first, reading 0 (moisture) last
    dvals = {16'h5AA5, 16'hFF00, 16'h00FF, 16'h7FFE, 16'h8001, 16'hFFFF, 16'h0000};
    make_frame(8'h01, 8'h03, 8'h0E, dvals);
    for (int i = 0; i < FRAME_LEN - 1; i++) add_row(ACT_BYTE, frame_buf[i]);
    add_typed(ACT_LAST, frame_buf[FRAME_LEN - 1], mk_result(1'b1, dvals, 1'b1, 7'd2));
    // lone last byte is a wrong length; readings and flag hold
    add_typed(ACT_LAST, 8'h5A, mk_result(1'b0, dvals, 1'b1, 7'd3));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      offer_beat(directed_rows[i].act, directed_rows[i].data, directed_rows[i].typed,
                 directed_rows[i].want);

    // Random phases, each under its own limit and idle pattern
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      write_failure_limit(limits[p]);
      idle_pct  = idle_tab[p];
      stall_pct = stall_tab[p];
      start     = items_sent;
      while (items_sent - start < ITEMS_PER_PHASE) begin
        if (p == 0 && !hold_done && items_sent - start >= 30) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
        if (p == 0 && !pause_done && items_sent - start >= 120) begin
          in_valid <= 1'b0;
          while (pending_reports.size() != 0) @(posedge clk);
          pause_done = 1'b1;
        end
        send_random_exchange();
      end
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/msrc_pkg.sv
src/msrc_frame_rx.sv
src/modbus_sensor_response_checker.sv
bench/modbus_sensor_response_checker_tb.sv
